// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== hdl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  localparam int unsigned COLS       = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLS * ROWS;

  localparam int unsigned ADDR_W  = $clog2(CELL_COUNT);
  localparam int unsigned CNT_W   = $clog2(CELL_COUNT + 1);
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;

  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;
  localparam logic [CHAR_W-1:0]  SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  function automatic logic [CELL_W-1:0] blank_cell(input logic [COLOR_W-1:0] color);
    return {color, SPACE_CHAR};
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/text_console_writer_core.sv =====
// Text console writer: an 80 by 25 grid of 16-bit cells (color over character)
// and a cursor, all cells held in one simple dual-port RAM.
// Input channel (in_valid_i/in_ready_o) takes one command word: put char, clear,
// set cursor or read cell. Output channel (out_valid_o/out_ready_i) returns one
// word per command: the cell read (zero for other commands) and the cursor after it.
// cfg_we_i/cfg_wdata_i write the default color at once, with no handshake.
// Put char and set cursor go straight to the output register; read cell goes through
// the registered RAM read first. A put that passes the last row scrolls: one RAM read
// and write per cell moved, for the 1920 cells, then the 80 bottom-row cells blanked.
// Clear writes all 2000 cells, one per cycle. Throughput is one put or set per cycle
// while the receiver keeps up, bounded by the single RAM write port.
// After reset all 2000 RAM cells are swept to blanks in color 0x0F, one cell per
// cycle; no command is taken meanwhile, configuration writes still are.
// A stalled receiver holds the result in the output register; one more finished
// result may wait inside, after which in_ready_o stays low until the output drains.
`default_nettype none
`include "assert_macros.svh"

module text_console_writer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tcw_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   char_color_i,
  input  wire logic                          use_default_color_i,
  input  wire logic [tcw_pkg::POS_W-1:0]     pos_x_i,
  input  wire logic [tcw_pkg::POS_W-1:0]     pos_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [tcw_pkg::CELL_W-1:0]    cell_value_o,
  output logic      [tcw_pkg::COL_W-1:0]     cursor_col_o,
  output logic      [tcw_pkg::ROW_W-1:0]     cursor_row_o
);

  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_WAIT_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COLOR_W-1:0] dflt_q, dflt_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [ADDR_W-1:0]  wptr_q, wptr_d;
  logic               copy_v_q, copy_v_d;
  logic [CELL_W-1:0]  cell_q, cell_d;
  logic               out_valid_q, out_valid_d;
  logic [CELL_W-1:0]  out_cell_q, out_cell_d;
  logic [COL_W-1:0]   out_col_q, out_col_d;
  logic [ROW_W-1:0]   out_row_q, out_row_d;

  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [CELL_W-1:0]  mem_wdata, mem_rdata;

  op_e                op;
  logic               in_fire;
  logic               fin;
  logic [CELL_W-1:0]  fin_cell;
  logic [COL_W:0]     col_inc;
  logic [ROW_W:0]     row_inc, nxt_row;
  logic [COL_W-1:0]   col_clamp;
  logic [ROW_W-1:0]   row_clamp;
  logic [COLOR_W-1:0] color_sel;

  assign op         = op_e'(opcode_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign row_inc    = {1'b0, row_q} + 1'b1;
  assign col_clamp  = (pos_x_i >= POS_W'(COLS)) ? COL_W'(COLS - 1) : pos_x_i[COL_W-1:0];
  assign row_clamp  = (pos_y_i >= POS_W'(ROWS)) ? ROW_W'(ROWS - 1) : pos_y_i[ROW_W-1:0];
  assign color_sel  = use_default_color_i ? dflt_q : char_color_i;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    dflt_d      = dflt_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    copy_v_d    = copy_v_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q;
    out_cell_d  = out_cell_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    fin         = 1'b0;
    fin_cell    = '0;
    nxt_row     = {1'b0, row_q};

    if (cfg_we_i) begin
      dflt_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[ADDR_W-1:0];
        mem_wdata = blank_cell(RESET_COLOR);
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == CNT_W'(CELL_COUNT - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_PUT: begin
              if (char_code_i == NEWLINE_CHAR) begin
                col_d   = '0;
                nxt_row = row_inc;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(row_q, col_q);
                mem_wdata = {color_sel, char_code_i};
                if (col_inc >= (COL_W + 1)'(COLS)) begin
                  col_d   = '0;
                  nxt_row = row_inc;
                end else begin
                  col_d = col_inc[COL_W-1:0];
                end
              end
              if (nxt_row >= (ROW_W + 1)'(ROWS)) begin
                // past the last row: move every row up one
                row_d    = ROW_W'(ROWS - 1);
                ptr_d    = CNT_W'(COLS);
                copy_v_d = 1'b0;
                state_d  = ST_SCROLL;
              end else begin
                row_d = nxt_row[ROW_W-1:0];
                fin   = 1'b1;
              end
            end
            OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              ptr_d   = '0;
              state_d = ST_FILL;
            end
            OP_SET: begin
              col_d = col_clamp;
              row_d = row_clamp;
              fin   = 1'b1;
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = cell_addr(row_clamp, col_clamp);
              state_d   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        fin      = 1'b1;
        fin_cell = mem_rdata;
      end
      ST_SCROLL: begin
        // write the word read last cycle one row lower in the address space
        mem_we    = copy_v_q;
        mem_waddr = wptr_q;
        mem_wdata = mem_rdata;
        if (ptr_q == CNT_W'(CELL_COUNT)) begin
          copy_v_d = 1'b0;
          ptr_d    = CNT_W'(CELL_COUNT - COLS);
          state_d  = ST_FILL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[ADDR_W-1:0];
          wptr_d    = ADDR_W'(ptr_q - CNT_W'(COLS));
          copy_v_d  = 1'b1;
          ptr_d     = ptr_q + 1'b1;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[ADDR_W-1:0];
        mem_wdata = blank_cell(dflt_q);
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == CNT_W'(CELL_COUNT - 1)) begin
          ptr_d = '0;
          fin   = 1'b1;
        end
      end
      ST_WAIT_OUT: begin
        fin      = 1'b1;
        fin_cell = cell_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        out_cell_d  = fin_cell;
        out_col_d   = col_d;
        out_row_d   = row_d;
        state_d     = ST_IDLE;
      end else begin
        // hold the finished word until the output register frees
        cell_d  = fin_cell;
        state_d = ST_WAIT_OUT;
      end
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      col_q       <= '0;
      row_q       <= '0;
      dflt_q      <= RESET_COLOR;
      ptr_q       <= '0;
      wptr_q      <= '0;
      copy_v_q    <= 1'b0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
      out_cell_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      dflt_q      <= dflt_d;
      ptr_q       <= ptr_d;
      wptr_q      <= wptr_d;
      copy_v_q    <= copy_v_d;
      cell_q      <= cell_d;
      out_valid_q <= out_valid_d;
      out_cell_q  <= out_cell_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_cell_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;

  `ASSERT_IMP(a_cursor_in_grid, 1'b1, (col_q < COL_W'(COLS)) && (row_q < ROW_W'(ROWS)))
  `ASSERT_IMP(a_idle_write_is_put, (state_q == ST_IDLE) && mem_we, in_fire && (op == OP_PUT))
  `ASSERT_NXT(a_fire_makes_progress, in_fire, out_valid_q || (state_q != ST_IDLE))

endmodule

`default_nettype wire

// ===== dv/text_console_writer_core_tb.sv =====
`default_nettype none

module text_console_writer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // Longest walk over the whole grid (scroll or clear), with margin.
  localparam int unsigned GRID_WALK_CYCLES = CELL_COUNT + 2 * COLS + 40;

  typedef struct packed {
    op_e                op;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
    logic               use_def;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [COLOR_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      opcode = '0;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [COLOR_W-1:0]   char_color = '0;
  logic                 use_default_color = 1'b0;
  logic [POS_W-1:0]     pos_x = '0;
  logic [POS_W-1:0]     pos_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    cell_value;
  logic [COL_W-1:0]     cursor_col;
  logic [ROW_W-1:0]     cursor_row;

  // Shadow of the console state.
  logic [CELL_W-1:0]  screen [CELL_COUNT];
  int unsigned        cur_col = 0;
  int unsigned        cur_row = 0;
  logic [COLOR_W-1:0] dflt_color = RESET_COLOR;

  status_t     pending_status[$];
  int unsigned mismatch_count = 0;

  // Sender pacing and receiver stall state.
  int unsigned burst_left = 0;
  bit          steady_feed = 1'b0;
  int unsigned hold_off_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned mask_bit = 0;
  logic [31:0] stall_mask = '1;

  text_console_writer_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .opcode_i            (opcode),
    .char_code_i         (char_code),
    .char_color_i        (char_color),
    .use_default_color_i (use_default_color),
    .pos_x_i             (pos_x),
    .pos_y_i             (pos_y),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .cell_value_o        (cell_value),
    .cursor_col_o        (cursor_col),
    .cursor_row_o        (cursor_row)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("text_console_writer_core_tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  function automatic int unsigned clamp_pos(input logic [POS_W-1:0] v,
                                            input int unsigned lim);
    return (v >= lim) ? lim - 1 : int'(v);
  endfunction

  function automatic void fill_blank(input logic [COLOR_W-1:0] color);
    for (int unsigned i = 0; i < CELL_COUNT; i++) begin
      screen[i] = {color, SPACE_CHAR};
    end
  endfunction

  // True when the word makes the block walk the whole grid.
  function automatic bit walks_grid(input cmd_t c);
    if (c.op == OP_CLEAR) return 1'b1;
    if (c.op != OP_PUT || cur_row != ROWS - 1) return 1'b0;
    return (c.ch == NEWLINE_CHAR) || (cur_col == COLS - 1);
  endfunction

  function automatic status_t console_step(input cmd_t c);
    status_t            r;
    logic [COLOR_W-1:0] paint;
    r.value = '0;
    paint = c.use_def ? dflt_color : c.color;
    unique case (c.op)
      OP_PUT: begin
        if (c.ch == NEWLINE_CHAR) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen[cur_row * COLS + cur_col] = {paint, c.ch};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Scroll up one row and blank the bottom row.
        if (cur_row >= ROWS) begin
          for (int unsigned i = COLS; i < CELL_COUNT; i++) begin
            screen[i - COLS] = screen[i];
          end
          for (int unsigned i = CELL_COUNT - COLS; i < CELL_COUNT; i++) begin
            screen[i] = {dflt_color, SPACE_CHAR};
          end
          cur_row = ROWS - 1;
        end
      end
      OP_CLEAR: begin
        fill_blank(dflt_color);
        cur_col = 0;
        cur_row = 0;
      end
      OP_SET: begin
        cur_col = clamp_pos(c.x, COLS);
        cur_row = clamp_pos(c.y, ROWS);
      end
      default: begin
        r.value = screen[clamp_pos(c.y, ROWS) * COLS + clamp_pos(c.x, COLS)];
      end
    endcase
    r.col = COL_W'(cur_col);
    r.row = ROW_W'(cur_row);
    return r;
  endfunction

  function automatic cmd_t word_of(input op_e op, input logic [CHAR_W-1:0] ch,
                                   input logic [COLOR_W-1:0] color, input logic use_def,
                                   input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    cmd_t c;
    c.op      = op;
    c.ch      = ch;
    c.color   = color;
    c.use_def = use_def;
    c.x       = x;
    c.y       = y;
    return c;
  endfunction

  // Offer one word, wait for it to be taken, then record its expected status.
  task automatic send_word(input cmd_t c);
    int unsigned gap;
    @(negedge clk_i);
    in_valid          <= 1'b1;
    opcode            <= c.op;
    char_code         <= c.ch;
    char_color        <= c.color;
    use_default_color <= c.use_def;
    pos_x             <= c.x;
    pos_y             <= c.y;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    pending_status.push_back(console_step(c));
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady_feed) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  // Write only when idle; a scroll or clear may still be walking the grid.
  task automatic write_default_color(input logic [COLOR_W-1:0] color);
    drain_results();
    repeat (GRID_WALK_CYCLES) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    dflt_color = color;
  endtask

  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected word", cell_value, 0);
      end else begin
        want = pending_status.pop_front();
        if (cell_value !== want.value) report_mismatch("cell_value", cell_value, want.value);
        if (cursor_col !== want.col) report_mismatch("cursor_col", cursor_col, want.col);
        if (cursor_row !== want.row) report_mismatch("cursor_row", cursor_row, want.row);
      end
    end
  end

  // Receiver: long hold-off on request, otherwise a changing stall mask.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 128);
        end
        mode_left--;
        if (mask_bit == 0) begin
          unique case (stall_mode)
            0: stall_mask = '1;
            1: stall_mask = $urandom;
            2: stall_mask = $urandom | $urandom;
            default: begin
              stall_mask = $urandom;
              stall_mask = {{8{stall_mask[0]}}, {8{stall_mask[1]}},
                            {8{stall_mask[2]}}, {8{stall_mask[3]}}};
            end
          endcase
        end
        out_ready <= stall_mask[mask_bit];
        mask_bit = (mask_bit + 1) % 32;
      end
    end
  end

  task automatic test_directed();
    send_word(word_of(OP_PUT, 8'h41, 8'h00, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_PUT, 8'hFF, 8'hFF, 1'b0, 8'hFF, 8'hFF));
    send_word(word_of(OP_PUT, 8'h00, 8'h33, 1'b1, 8'd0, 8'd0));
    send_word(word_of(OP_PUT, NEWLINE_CHAR, 8'hAA, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd1, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd2, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd3, 8'd0));
    // wrap at the line end
    send_word(word_of(OP_SET, 8'h00, 8'h00, 1'b0, 8'(COLS - 1), 8'd0));
    send_word(word_of(OP_PUT, 8'h5A, 8'h3C, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'hFF, 8'd0));
    // wrap past the last row, then newline on the last row: both scroll
    send_word(word_of(OP_SET, 8'h00, 8'h00, 1'b0, 8'hFF, 8'hFF));
    send_word(word_of(OP_PUT, 8'h7E, 8'h5A, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'(COLS - 1), 8'(ROWS - 2)));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'hFF));
    send_word(word_of(OP_PUT, NEWLINE_CHAR, 8'h12, 1'b1, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'(COLS - 1), 8'(ROWS - 3)));
    // clamp each axis on its own
    send_word(word_of(OP_SET, 8'h00, 8'h00, 1'b0, 8'(COLS), 8'(ROWS)));
    send_word(word_of(OP_SET, 8'h00, 8'h00, 1'b0, 8'd0, 8'hFF));
    send_word(word_of(OP_SET, 8'h00, 8'h00, 1'b0, 8'd200, 8'd3));
    send_word(word_of(OP_CLEAR, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'hFF, 8'hFF));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'(COLS - 1), 8'(ROWS - 3)));
    drain_results();
  endtask

  // Hold the receiver off while words keep coming so the block backs up.
  task automatic test_backpressure();
    int unsigned k;
    steady_feed = 1'b1;
    hold_off_cycles = 400;
    for (k = 0; k < 48; k++) begin
      case (k % 3)
        0: send_word(word_of(OP_SET, 8'h00, 8'h00, 1'b0, 8'($urandom_range(0, COLS - 1)),
                             8'($urandom_range(0, ROWS - 2))));
        1: send_word(word_of(OP_PUT, 8'($urandom_range(32, 126)), 8'($urandom),
                             1'($urandom), 8'd0, 8'd0));
        default: send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'(cur_col - 1),
                                   8'(cur_row)));
      endcase
    end
    steady_feed = 1'b0;
    drain_results();
  endtask

  task automatic test_color_phase(input logic [COLOR_W-1:0] color);
    write_default_color(color);
    send_word(word_of(OP_CLEAR, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_PUT, 8'h78, 8'($urandom), 1'b1, 8'd0, 8'd0));
    send_word(word_of(OP_PUT, 8'h79, ~color, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd1, 8'd0));
    send_word(word_of(OP_SET, 8'h00, 8'h00, 1'b0, 8'd5, 8'(ROWS - 1)));
    send_word(word_of(OP_PUT, NEWLINE_CHAR, 8'h00, 1'b1, 8'd0, 8'd0));
    send_word(word_of(OP_READ, 8'h00, 8'h00, 1'b0, 8'd40, 8'(ROWS - 1)));
  endtask

  task automatic test_random_traffic(input int unsigned n_words);
    cmd_t        c;
    int unsigned roll;
    int unsigned walks_left;
    int unsigned k;
    walks_left = n_words / 12;
    for (k = 0; k < n_words; k++) begin
      roll = $urandom_range(0, 99);
      c = word_of(OP_PUT, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                  8'($urandom));
      if (roll < 55) begin
        if ($urandom_range(0, 7) == 0) c.ch = NEWLINE_CHAR;
      end else if (roll < 72) begin
        c.op = OP_SET;
        // favor the line end and the last row to provoke wraps and scrolls
        if ($urandom_range(0, 2) == 0) c.x = 8'($urandom_range(COLS - 4, COLS - 1));
        else if ($urandom_range(0, 1) == 1) c.x = 8'($urandom_range(0, COLS - 1));
        if ($urandom_range(0, 2) == 0) c.y = 8'(ROWS - 1);
        else if ($urandom_range(0, 1) == 1) c.y = 8'($urandom_range(0, ROWS - 1));
      end else if (roll < 98) begin
        c.op = OP_READ;
        if ($urandom_range(0, 3) != 0) begin
          c.x = 8'($urandom_range(0, COLS - 1));
          c.y = (cur_row > 0 && $urandom_range(0, 1) == 1) ? 8'(cur_row - 1) : 8'(cur_row);
        end
      end else begin
        c.op = OP_CLEAR;
      end
      // cap full-grid walks to keep the run short
      if (walks_grid(c)) begin
        if (walks_left == 0) c.op = OP_READ;
        else walks_left--;
      end
      send_word(c);
    end
  endtask

  initial begin
    fill_blank(RESET_COLOR);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_color_phase(8'h00);
    test_random_traffic(350);
    test_color_phase(8'hFF);
    test_random_traffic(350);
    test_color_phase(8'($urandom));
    test_random_traffic(350);
    test_color_phase(RESET_COLOR);
    test_random_traffic(350);
    drain_results();
    repeat (GRID_WALK_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("text_console_writer_core_tb: clean");
    end else begin
      $display("text_console_writer_core_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
